// File: sv/spdd_pkg.sv
// Package for the smoothed peak direction detector: widths, codes, control types.
package spdd_pkg;

    localparam int DATA_W     = 16;
    localparam int WINDOW_DEF = 8;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [1:0] TREND_UNKNOWN = 2'd0;
    localparam logic [1:0] TREND_RISING  = 2'd1;
    localparam logic [1:0] TREND_FALLING = 2'd2;

    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_HYSTERESIS = 1'b1;

    typedef struct packed {
        logic load;
        logic acc;
        logic step;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic out_stall;
    } t_sts;

endpackage

// File: sv/spdd_ctrl.sv
// Sequencer for the detector: accept, accumulate, divide, evaluate.
module spdd_ctrl #(
    parameter int SUM_W = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  spdd_pkg::t_sts i_sts,
    output spdd_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EVAL = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt     = CNT_W'(SUM_W - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_EVAL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_EVAL: begin
                if (!i_sts.out_stall) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: sv/spdd_dpath.sv
// Datapath: sample ring, running sum, serial divider, peak tracking, output register.
module spdd_dpath #(
    parameter int WINDOW = spdd_pkg::WINDOW_DEF,
    parameter int SUM_W  = 19
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spdd_pkg::t_cmd                      i_cmd,
    output spdd_pkg::t_sts                      o_sts,
    input  logic signed [spdd_pkg::DATA_W-1:0]  i_sample,
    input  logic signed [spdd_pkg::DATA_W-1:0]  i_threshold,
    input  logic        [spdd_pkg::DATA_W-1:0]  i_hysteresis,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_peak_event,
    output logic signed [spdd_pkg::DATA_W-1:0]  o_peak_value,
    output logic                                o_peak_direction
);

    localparam int DW     = spdd_pkg::DATA_W;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic signed [DW-1:0]     r_ring [WINDOW];
    logic signed [DW-1:0]     r_rd;
    logic signed [DW-1:0]     r_sample;
    logic signed [SUM_W-1:0]  r_sum;
    logic [FILL_W-1:0]        r_fill;
    logic [SLOT_W-1:0]        r_slot;

    logic [SUM_W-1:0]         r_quo;
    logic [FILL_W-1:0]        r_rem;
    logic [FILL_W-1:0]        r_div;
    logic                     r_neg;

    logic signed [DW-1:0]     r_prev;
    logic signed [DW-1:0]     r_peak;
    logic                     r_tracking;
    logic [1:0]               r_trend;

    logic                     r_out_valid;
    logic                     r_ev;
    logic signed [DW-1:0]     r_pv;
    logic                     r_pd;

    logic                     full;
    logic signed [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0]        n_fill;
    logic [SLOT_W-1:0]        n_slot;
    logic [SUM_W-1:0]         mag;

    logic [FILL_W:0]          rem_sh;
    logic [FILL_W:0]          rem_diff;

    logic signed [DW-1:0]     q16;
    logic signed [DW-1:0]     s;
    logic                     above;
    logic                     start;
    logic signed [DW-1:0]     peak_cur;
    logic [1:0]               trend_cur;
    logic                     newmax;
    logic signed [DW-1:0]     n_peak;
    logic [1:0]               n_trend;
    logic signed [DW:0]       drop;
    logic                     drop_ok;
    logic                     ev;

    assign o_sts.out_stall = r_out_valid && !i_ready;

    // window accumulate
    always_comb begin
        full   = (r_fill == FILL_W'(WINDOW));
        n_fill = full ? r_fill : r_fill + 1'b1;
        n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        n_sum  = r_sum + SUM_W'(r_sample) - (full ? SUM_W'(r_rd) : '0);
        mag    = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    // restoring divide, one quotient bit per step
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
    end

    // peak tracking
    always_comb begin
        q16       = r_quo[DW-1:0];
        s         = r_neg ? -q16 : q16;
        above     = (s > i_threshold);
        start     = above && !r_tracking;
        peak_cur  = start ? s : r_peak;
        trend_cur = start ? spdd_pkg::TREND_UNKNOWN : r_trend;
        newmax    = above && (s > peak_cur);
        n_peak    = newmax ? s : peak_cur;
        if (newmax) begin
            n_trend = (s >= r_prev) ? spdd_pkg::TREND_RISING : spdd_pkg::TREND_FALLING;
        end else begin
            n_trend = trend_cur;
        end
        drop    = (DW + 1)'(n_peak) - (DW + 1)'(s);
        drop_ok = ($signed({drop[DW], drop}) >= $signed({2'b00, i_hysteresis}));
        ev      = above && drop_ok && (n_trend != spdd_pkg::TREND_UNKNOWN);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_rd     <= r_ring[r_slot];
        end
        if (i_cmd.acc) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= n_fill;
            r_neg <= n_sum[SUM_W-1];
        end else if (i_cmd.step) begin
            if (!rem_diff[FILL_W]) begin
                r_rem <= rem_diff[FILL_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[FILL_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.eval) begin
            r_ev <= ev;
            r_pv <= ev ? n_peak : '0;
            r_pd <= ev && (n_trend == spdd_pkg::TREND_FALLING);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_prev      <= '0;
            r_peak      <= '0;
            r_tracking  <= 1'b0;
            r_trend     <= spdd_pkg::TREND_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_slot <= n_slot;
            end
            if (i_cmd.eval) begin
                if (above) begin
                    r_peak  <= n_peak;
                    r_trend <= n_trend;
                end
                r_tracking  <= above && !ev;
                r_prev      <= s;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_peak_event     = r_ev;
    assign o_peak_value     = r_pv;
    assign o_peak_direction = r_pd;

endmodule

// File: sv/smoothed_peak_direction_detector_core.sv
// Top level of the smoothed peak direction detector: register port, sequencer and datapath.
// Each sample transaction yields one result transaction. Each sample is accepted and its
// ring slot read, then the running sum is updated, then the sum (SUM_W = 16 + clog2(WINDOW)
// bits) is divided bit-serially by the fill count, and then the peak tracker is evaluated
// into the output register. A new sample is taken while a finished result still waits;
// evaluation holds only if the output register is still occupied. Registers: 0x0
// level_threshold (signed 16 bit), 0x4 drop_hysteresis (unsigned 16 bit); write them only
// while the block is idle.
module smoothed_peak_direction_detector_core #(
    parameter int WINDOW = spdd_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [spdd_pkg::DATA_W-1:0]  i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_peak_event,
    output logic signed [spdd_pkg::DATA_W-1:0]  o_peak_value,
    output logic                                o_peak_direction,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spdd_pkg::APB_AW-1:0]         paddr,
    input  logic [spdd_pkg::APB_DW-1:0]         pwdata,
    output logic [spdd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int DW    = spdd_pkg::DATA_W;
    localparam int SUM_W = DW + $clog2(WINDOW);

    logic signed [DW-1:0] r_threshold;
    logic        [DW-1:0] r_hysteresis;
    logic                 wr_en;
    spdd_pkg::t_cmd       cmd;
    spdd_pkg::t_sts       sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_hysteresis <= '0;
        end else if (wr_en) begin
            case (paddr[2])
                spdd_pkg::REG_THRESHOLD:  r_threshold  <= pwdata[DW-1:0];
                spdd_pkg::REG_HYSTERESIS: r_hysteresis <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            spdd_pkg::REG_THRESHOLD:  prdata = spdd_pkg::APB_DW'(r_threshold);
            spdd_pkg::REG_HYSTERESIS: prdata = {{(spdd_pkg::APB_DW - DW){1'b0}}, r_hysteresis};
            default:                  prdata = '0;
        endcase
    end

    spdd_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spdd_dpath #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_sample         (i_sample),
        .i_threshold      (r_threshold),
        .i_hysteresis     (r_hysteresis),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_peak_event     (o_peak_event),
        .o_peak_value     (o_peak_value),
        .o_peak_direction (o_peak_direction)
    );

endmodule

// File: tb/tb.sv
// Testbench for the smoothed peak direction detector: register setup, sample driver, scoreboard.
`timescale 1ns / 100ps

module tb;

    localparam int DW             = spdd_pkg::DATA_W;
    localparam int ITEMS          = 1550;
    localparam int QUIET_TAIL     = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic                 found;
        logic signed [DW-1:0] level;
        logic                 falling;
    } t_peak_report;

    class peak_scoreboard;
        logic signed [DW-1:0] threshold = '0;
        logic [DW-1:0]        hysteresis = '0;
        logic signed [DW-1:0] ring [spdd_pkg::WINDOW_DEF];
        int                   ring_total = 0;
        int                   held = 0;
        int                   slot = 0;
        int                   last_avg = 0;
        int                   peak = 0;
        bit                   tracking = 0;
        logic [1:0]           trend = spdd_pkg::TREND_UNKNOWN;
        t_peak_report         expected_reports [$];
        int                   errors = 0;

        function new();
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function void set_reg(logic idx, logic [DW-1:0] val);
            case (idx)
                spdd_pkg::REG_THRESHOLD:  threshold = val;
                spdd_pkg::REG_HYSTERESIS: hysteresis = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void report(string what);
            $display("tb: mismatch: %s", what);
            errors++;
        endfunction

        // moving average, then peak tracking on the smoothed value
        function void note_sample(logic signed [DW-1:0] x);
            t_peak_report r;
            int avg;
            int thr;
            int hys;
            r = '0;
            thr = int'(threshold);
            hys = int'(hysteresis);
            if (held < spdd_pkg::WINDOW_DEF) begin
                held++;
            end else begin
                ring_total -= int'(ring[slot]);
            end
            ring_total += int'(x);
            ring[slot] = x;
            slot = (slot + 1) % spdd_pkg::WINDOW_DEF;
            avg = ring_total / held;
            if (avg > thr) begin
                if (!tracking) begin
                    tracking = 1;
                    peak = avg;
                    trend = spdd_pkg::TREND_UNKNOWN;
                end
                if (avg > peak) begin
                    peak = avg;
                    trend = (avg >= last_avg) ? spdd_pkg::TREND_RISING
                                              : spdd_pkg::TREND_FALLING;
                end
                if (peak - avg >= hys && trend != spdd_pkg::TREND_UNKNOWN) begin
                    r.found = 1'b1;
                    r.level = peak[DW-1:0];
                    r.falling = (trend == spdd_pkg::TREND_FALLING);
                    tracking = 0;
                end
            end else begin
                tracking = 0;
            end
            last_avg = avg;
            expected_reports.push_back(r);
        endfunction

        function void check_result(logic found, logic signed [DW-1:0] level, logic falling);
            t_peak_report r;
            if (expected_reports.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            r = expected_reports.pop_front();
            if (found !== r.found)
                report($sformatf("peak_event got %b want %b", found, r.found));
            if (level !== r.level)
                report($sformatf("peak_value got %0d want %0d", level, r.level));
            if (falling !== r.falling)
                report($sformatf("peak_direction got %b want %b", falling, r.falling));
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic signed [DW-1:0]              i_sample = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic                              o_peak_event;
    logic signed [DW-1:0]              o_peak_value;
    logic                              o_peak_direction;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [spdd_pkg::APB_AW-1:0]       paddr = '0;
    logic [spdd_pkg::APB_DW-1:0]       pwdata = '0;
    logic [spdd_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    peak_scoreboard sb = new();
    int             items_sent = 0;
    int             cur_thr = 0;
    bit             idle_on = 1;
    bit             hold_req = 0;
    int             quiet_cycles = 0;

    smoothed_peak_direction_detector_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_peak_event    (o_peak_event),
        .o_peak_value    (o_peak_value),
        .o_peak_direction(o_peak_direction),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_peak_event, o_peak_value, o_peak_direction);
            if (i_valid && o_ready)
                sb.note_sample(i_sample);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    function automatic logic signed [DW-1:0] clamp16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[DW-1:0];
    endfunction

    task automatic send_sample(logic signed [DW-1:0] v);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic config_block(logic signed [DW-1:0] thr, logic [DW-1:0] hys);
        write_reg(spdd_pkg::REG_THRESHOLD, thr);
        write_reg(spdd_pkg::REG_HYSTERESIS, hys);
        cur_thr = int'(thr);
    endtask

    // smooth rise from at or below the threshold to a crest above it, then back down
    task automatic play_bump();
        int base;
        int top;
        int nup;
        int ndn;
        int noise;
        int v;
        base = cur_thr - int'($urandom_range(0, 4000));
        top = cur_thr + int'($urandom_range(50, 12000));
        nup = $urandom_range(3, 16);
        ndn = $urandom_range(3, 16);
        noise = $urandom_range(0, 300);
        for (int k = 0; k < nup; k++) begin
            v = base + (top - base) * k / nup + int'($urandom_range(0, 2 * noise)) - noise;
            send_sample(clamp16(v));
        end
        for (int k = 0; k <= ndn; k++) begin
            v = top - (top - base) * k / ndn + int'($urandom_range(0, 2 * noise)) - noise;
            send_sample(clamp16(v));
        end
    endtask

    initial begin
        int                   dir_a [12] = '{32767, 32767, -32768, -32768, 100, 2000,
                                             1500, -1, 0, 1, -32768, 32767};
        int                   dir_b [4] = '{-32768, 32767, 21845, -21846};
        int                   dir_d [6] = '{0, 400, 800, 1200, 400, 0};
        int                   phase;
        int                   phase_end;
        logic signed [DW-1:0] thr_cfg;
        logic [DW-1:0]        hys_cfg;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, partial window, trend still unknown
        foreach (dir_a[k]) send_sample(DW'(dir_a[k]));
        drain_and_settle();
        config_block(16'sh8000, 16'hffff);
        foreach (dir_b[k]) send_sample(DW'(dir_b[k]));
        drain_and_settle();
        config_block(16'sh7fff, 16'h0000);
        repeat (3) send_sample(16'sh7fff);
        drain_and_settle();
        config_block(16'sd300, 16'd40);
        foreach (dir_d[k]) send_sample(DW'(dir_d[k]));
        drain_and_settle();

        phase = 0;
        while (items_sent < ITEMS) begin
            if (phase == 0) begin
                thr_cfg = 16'sh8000;
                hys_cfg = 16'h0000;
            end else begin
                case ($urandom_range(0, 4))
                    0: thr_cfg = 16'sh8000;
                    1: thr_cfg = DW'($urandom);
                    default: thr_cfg = DW'(int'($urandom_range(0, 6000)) - 3000);
                endcase
                case ($urandom_range(0, 5))
                    0: hys_cfg = 16'h0000;
                    1: hys_cfg = DW'($urandom);
                    default: hys_cfg = DW'($urandom_range(0, 2000));
                endcase
            end
            config_block(thr_cfg, hys_cfg);
            idle_on = (items_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (phase == 2) hold_req = 1;
            phase_end = items_sent + $urandom_range(90, 170);
            while (items_sent < phase_end && items_sent < ITEMS) begin
                if (items_sent >= ITEMS - QUIET_TAIL) idle_on = 0;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 6)) send_sample(DW'($urandom));
                else
                    play_bump();
            end
            drain_and_settle();
            phase++;
        end

        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
